@@ rtl/wmm_pkg.sv @@
`default_nettype none
package wmm_pkg;

  localparam int MaxWidth   = 512;
  localparam int MaxHeight  = 512;
  localparam int MaxRadius  = 3;
  localparam int HistDepth  = 2 * MaxRadius * MaxWidth + 2 * MaxRadius + 1;
  localparam int WinMax     = (2 * MaxRadius + 1) * (2 * MaxRadius + 1);
  localparam int AddrW      = $clog2(HistDepth);
  localparam int CountW     = 19;
  localparam int SumW       = 14;
  localparam int WinIdxW    = $clog2(WinMax);

  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegRadius = 3'd1;
  localparam logic [2:0] RegLeft   = 3'd2;
  localparam logic [2:0] RegTop    = 3'd3;
  localparam logic [2:0] RegRight  = 3'd4;
  localparam logic [2:0] RegBottom = 3'd5;
  localparam logic [2:0] RegWidth  = 3'd6;
  localparam logic [2:0] RegHeight = 3'd7;

  typedef struct packed {
    logic       vld;
    logic [7:0] val;
  } cell_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_CHECK, ST_DIVO, ST_POS, ST_READV,
    ST_WIN, ST_DRAIN, ST_DIVST, ST_DIVS, ST_EMIT
  } state_t;

  // Window size (2r+1)^2 for each radius.
  function automatic logic [9:0] win_count(input logic [1:0] r);
    case (r)
      2'd0:    win_count = 10'd1;
      2'd1:    win_count = 10'd9;
      2'd2:    win_count = 10'd25;
      default: win_count = 10'd49;
    endcase
  endfunction

  // Rank of the median in the sorted window, 2r^2+2r.
  function automatic logic [WinIdxW-1:0] med_rank(input logic [1:0] r);
    case (r)
      2'd0:    med_rank = WinIdxW'(0);
      2'd1:    med_rank = WinIdxW'(4);
      2'd2:    med_rank = WinIdxW'(12);
      default: med_rank = WinIdxW'(24);
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/wmm_cell.sv @@
`default_nettype none
module wmm_cell (
  input  wire              clk,
  input  wire              clear,
  input  wire              ins,
  input  wire  [7:0]       pix,
  input  wmm_pkg::cell_t   prev,
  output wmm_pkg::cell_t   cur
);
  wmm_pkg::cell_t cur_r;
  logic below_self;
  logic below_prev;

  // An empty cell acts as +infinity, so the sorted row fills from the front.
  assign below_self = !cur_r.vld || (pix < cur_r.val);
  assign below_prev = !prev.vld || (pix < prev.val);

  always_ff @(posedge clk) begin
    if (clear) begin
      cur_r.vld <= 1'b0;
    end else if (ins && below_self) begin
      if (below_prev) begin
        cur_r <= prev;
      end else begin
        cur_r.vld <= 1'b1;
        cur_r.val <= pix;
      end
    end
  end

  assign cur = cur_r;
endmodule
`default_nettype wire

@@ rtl/wmm_div.sv @@
`default_nettype none
module wmm_div (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire  [wmm_pkg::CountW-1:0]      dividend,
  input  wire  [9:0]                      divisor,
  output logic                            busy,
  output logic                            done,
  output logic [wmm_pkg::CountW-1:0]      quot,
  output logic [9:0]                      rem
);
  localparam int CntW = $clog2(wmm_pkg::CountW + 1);

  logic [wmm_pkg::CountW-1:0] q_r;
  logic [10:0]                rem_r;
  logic [9:0]                 dvs_r;
  logic [CntW-1:0]            cnt_r;
  logic                       done_r;
  logic [10:0]                rem_sh;
  logic                       ge;

  assign rem_sh = {rem_r[9:0], q_r[wmm_pkg::CountW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CntW'(wmm_pkg::CountW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[wmm_pkg::CountW-2:0], ge};
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r[9:0];
endmodule
`default_nettype wire

@@ rtl/window_mean_median_filter_top.sv @@
// Sliding-window mean / median filter for an 8-bit gray raster stream.
// Input channel (in_valid, in_stall, in_pixel): one pixel per request in
// raster order; after the last pixel of a frame, radius*width+radius padding
// requests flush the tail. Output channel (out_valid, out_stall, out_*):
// each pixel comes back radius rows plus radius columns later with its
// column, row, a filtered flag and a last flag on the final pixel.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready
// and should be written only between requests.
// One request is processed at a time. A request that yields no result does
// not use the divider; a pass-through pixel takes one pass of the 19-step
// shared divider, which finds column and row. A filtered pixel adds one
// history memory read per window pixel, plus a second divider pass for the
// mean.
// A result waits in the output register while the receiver stalls; the next
// request is still taken and runs until it has a result of its own.
// Synchronous reset restores the register defaults and starts a new frame.
// The history memory is not cleared; it is always written before it is read.
`default_nettype none
module window_mean_median_filter_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_pixel,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_value,
  output logic [8:0]  out_col,
  output logic [8:0]  out_row,
  output logic        out_filtered,
  output logic        out_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [9:0]  cfg_data
);
  localparam int AW = wmm_pkg::AddrW;
  localparam int CW = wmm_pkg::CountW;
  localparam logic [AW:0] Hd = (AW+1)'(wmm_pkg::HistDepth);

  // Configuration registers.
  logic       mode_r;
  logic [1:0] radius_r;
  logic [8:0] left_r, top_r, right_r, bottom_r;
  logic [9:0] fw_r, fh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      radius_r <= 2'd1;
      left_r   <= 9'd0;
      top_r    <= 9'd0;
      right_r  <= 9'd399;
      bottom_r <= 9'd399;
      fw_r     <= 10'd400;
      fh_r     <= 10'd400;
    end else if (cfg_valid) begin
      case (cfg_index)
        wmm_pkg::RegMode:   mode_r   <= cfg_data[0];
        wmm_pkg::RegRadius: radius_r <= cfg_data[1:0];
        wmm_pkg::RegLeft:   left_r   <= cfg_data[8:0];
        wmm_pkg::RegTop:    top_r    <= cfg_data[8:0];
        wmm_pkg::RegRight:  right_r  <= cfg_data[8:0];
        wmm_pkg::RegBottom: bottom_r <= cfg_data[8:0];
        wmm_pkg::RegWidth:  fw_r     <= cfg_data;
        wmm_pkg::RegHeight: fh_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [9:0] w, h;
  assign w = (fw_r == 10'd0) ? 10'd1 : (fw_r > 10'd512) ? 10'd512 : fw_r;
  assign h = (fh_r == 10'd0) ? 10'd1 : (fh_r > 10'd512) ? 10'd512 : fh_r;

  wmm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, total_r, o_r;
  logic [10:0]   delay_r;
  logic [AW-1:0] wp_r, oaddr_r, baddr_r, addr_r;
  logic [7:0]    pix_r, val_r, res_r;
  logic [8:0]    col_r, row_r;
  logic          filt_r, last_r;
  logic [2:0]    dx_r, dy_r;
  logic          rd_v_r;
  logic [wmm_pkg::SumW-1:0] sum_r;

  // Modular address arithmetic on the circular history.
  function automatic logic [AW-1:0] sub_wrap(input logic [AW-1:0] a,
                                             input logic [10:0] d);
    logic [AW:0] diff;
    diff = {1'b0, a} - (AW+1)'(d);
    if (diff[AW]) begin
      diff = diff + Hd;
    end
    sub_wrap = diff[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a,
                                             input logic [9:0] d);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(d);
    if (s >= Hd) begin
      s = s - Hd;
    end
    add_wrap = s[AW-1:0];
  endfunction

  logic [CW-1:0] o_now;
  logic [AW-1:0] wp_inc;
  logic [2:0]    side;
  logic          win_end;

  assign o_now   = count_r - CW'(delay_r);
  assign wp_inc  = (wp_r == AW'(wmm_pkg::HistDepth - 1)) ? '0 : wp_r + AW'(1);
  assign side    = {radius_r, 1'b0};
  assign win_end = (dx_r == side) && (dy_r == side);

  // History memory, one port.
  logic [7:0]    mem [wmm_pkg::HistDepth];
  logic [7:0]    q_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;

  assign mem_we   = (state_r == wmm_pkg::ST_CHECK) && (count_r < total_r);
  assign mem_addr = (state_r == wmm_pkg::ST_CHECK) ? wp_r :
                    (state_r == wmm_pkg::ST_POS)   ? oaddr_r : addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= pix_r;
    end
    q_r <= mem[mem_addr];
  end

  // Shared divider: position split first, then the window mean.
  logic          div_start, div_busy, div_done;
  logic [CW-1:0] div_dvd, div_q;
  logic [9:0]    div_dvs, div_rem;

  assign div_start = ((state_r == wmm_pkg::ST_CHECK) && (count_r >= CW'(delay_r)) &&
                      (o_now < total_r)) || (state_r == wmm_pkg::ST_DIVST);
  assign div_dvd   = (state_r == wmm_pkg::ST_DIVST) ? CW'(sum_r) : o_now;
  assign div_dvs   = (state_r == wmm_pkg::ST_DIVST) ? wmm_pkg::win_count(radius_r) : w;

  wmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // Sorting chain: each cell keeps one rank of the window.
  wmm_pkg::cell_t chain [wmm_pkg::WinMax];
  logic chain_clear;
  assign chain_clear = (state_r == wmm_pkg::ST_READV);

  genvar gi;
  generate
    for (gi = 0; gi < wmm_pkg::WinMax; gi++) begin : g_cell
      wmm_pkg::cell_t prev;
      if (gi == 0) begin : g_head
        assign prev = '{vld: 1'b1, val: 8'd0};
      end else begin : g_body
        assign prev = chain[gi-1];
      end
      wmm_cell u_cell (
        .clk   (clk),
        .clear (chain_clear),
        .ins   (rd_v_r),
        .pix   (q_r),
        .prev  (prev),
        .cur   (chain[gi])
      );
    end
  endgenerate

  // Position test done on the divider result.
  logic [8:0]  col_c, row_c;
  logic        filt_c;
  assign col_c  = div_rem[8:0];
  assign row_c  = div_q[8:0];
  assign filt_c = (col_c > left_r) && (row_c > top_r) && (col_c < right_r) &&
                  (row_c < bottom_r) && (col_c >= 9'(radius_r)) &&
                  (row_c >= 9'(radius_r)) &&
                  ((10'(col_c) + 10'(radius_r)) < w) &&
                  ((10'(row_c) + 10'(radius_r)) < h);

  logic emit_go;
  assign emit_go  = (state_r == wmm_pkg::ST_EMIT) && (!out_valid || !out_stall);
  assign in_stall = (state_r != wmm_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wmm_pkg::ST_IDLE:  if (in_valid) state_nxt = wmm_pkg::ST_SETUP;
      wmm_pkg::ST_SETUP: state_nxt = wmm_pkg::ST_CHECK;
      wmm_pkg::ST_CHECK: state_nxt = div_start ? wmm_pkg::ST_DIVO : wmm_pkg::ST_IDLE;
      wmm_pkg::ST_DIVO:  if (div_done) state_nxt = wmm_pkg::ST_POS;
      wmm_pkg::ST_POS:   state_nxt = wmm_pkg::ST_READV;
      wmm_pkg::ST_READV: state_nxt = filt_r ? wmm_pkg::ST_WIN : wmm_pkg::ST_EMIT;
      wmm_pkg::ST_WIN:   if (win_end) state_nxt = wmm_pkg::ST_DRAIN;
      wmm_pkg::ST_DRAIN: state_nxt = wmm_pkg::ST_DIVST;
      wmm_pkg::ST_DIVST: state_nxt = wmm_pkg::ST_DIVS;
      wmm_pkg::ST_DIVS:  if (div_done) state_nxt = wmm_pkg::ST_EMIT;
      wmm_pkg::ST_EMIT:  if (emit_go) state_nxt = wmm_pkg::ST_IDLE;
      default:           state_nxt = wmm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmm_pkg::ST_IDLE;
      count_r <= '0;
      wp_r    <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == wmm_pkg::ST_WIN);
      if (state_r == wmm_pkg::ST_CHECK) begin
        if (count_r < CW'(delay_r)) begin
          count_r <= count_r + CW'(1);
          wp_r    <= wp_inc;
        end else if (o_now >= total_r) begin
          count_r <= '0;
          wp_r    <= '0;
        end
      end else if (emit_go) begin
        if (last_r) begin
          count_r <= '0;
          wp_r    <= '0;
        end else begin
          count_r <= count_r + CW'(1);
          wp_r    <= wp_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == wmm_pkg::ST_IDLE) begin
      pix_r <= in_pixel;
    end
    if (state_r == wmm_pkg::ST_SETUP) begin
      total_r <= CW'(w) * CW'(h);
      delay_r <= 11'(radius_r) * 11'(w) + 11'(radius_r);
    end
    if (state_r == wmm_pkg::ST_CHECK) begin
      o_r     <= o_now;
      oaddr_r <= sub_wrap(wp_r, delay_r);
    end
    if ((state_r == wmm_pkg::ST_DIVO) && div_done) begin
      col_r  <= col_c;
      row_r  <= row_c;
      filt_r <= filt_c;
      last_r <= (o_r == total_r - CW'(1));
    end
    if (state_r == wmm_pkg::ST_POS) begin
      baddr_r <= sub_wrap(oaddr_r, delay_r);
    end
    if (state_r == wmm_pkg::ST_READV) begin
      val_r  <= q_r;
      res_r  <= q_r;
      addr_r <= baddr_r;
      dx_r   <= '0;
      dy_r   <= '0;
      sum_r  <= '0;
    end
    if (state_r == wmm_pkg::ST_WIN) begin
      if (dx_r == side) begin
        dx_r   <= '0;
        dy_r   <= dy_r + 3'd1;
        addr_r <= add_wrap(addr_r, w - 10'(side));
      end else begin
        dx_r   <= dx_r + 3'd1;
        addr_r <= add_wrap(addr_r, 10'd1);
      end
    end
    if (rd_v_r) begin
      sum_r <= sum_r + wmm_pkg::SumW'(q_r);
    end
    if ((state_r == wmm_pkg::ST_DIVS) && div_done) begin
      res_r <= mode_r ? chain[wmm_pkg::med_rank(radius_r)].val : div_q[7:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_value    <= filt_r ? res_r : val_r;
      out_col      <= col_r;
      out_row      <= row_r;
      out_filtered <= filt_r;
      out_last     <= last_r;
    end
  end

  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !div_busy)
    else $error("divider busy when a new request is taken");

  a_window_only_filtered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmm_pkg::ST_WIN) |-> filt_r)
    else $error("window read for a pass-through pixel");

  a_reads_done_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmm_pkg::ST_EMIT) |-> !rd_v_r)
    else $error("window read still in flight at emit");

endmodule
`default_nettype wire
